// ===== rtl/core/frt_pkg.sv =====
package frt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADRANGE = 2'd3;

    typedef struct packed {
        logic [63:0] start_a;
        logic [63:0] end_a;
        logic [63:0] owner;
        logic [63:0] recovery;
        logic [63:0] guest;
    } entry_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] address;
        logic [63:0] end_address;
        logic [63:0] owner_address;
        logic [63:0] recovery_address;
        logic [63:0] guest_location;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] hit_start;
        logic [63:0] hit_end;
        logic [63:0] hit_owner;
        logic [63:0] hit_recovery;
        logic [63:0] hit_guest;
        logic [6:0]  removed_count;
    } out_word_t;

endpackage

// ===== rtl/core/frt_if.sv =====
interface frt_in_if;
    logic                 valid;
    logic                 ready;
    frt_pkg::in_word_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface frt_out_if;
    logic                 valid;
    logic                 ready;
    frt_pkg::out_word_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fault_range_table_top.sv =====
// Each word is handled alone: insert scans for its place, then shifts entries up and writes;
// lookup scans all entries downward, then fetches the hit; remove compacts the table in one pass.
// Throughput: one word at a time; each table entry moved is a read followed by a write.
// A new word is accepted the cycle after the previous result has been taken.
// Reset (rst_n, asynchronous, active low) empties the table and idles the sequencer.
// Table contents are not cleared; only entries below the fill count are ever read.
module fault_range_table_top (
    input  logic         clk,
    input  logic         rst_n,
    frt_in_if.sink       in_ch,
    frt_out_if.source    out_ch
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_IFIND  = 4'd1;
    localparam logic [3:0] S_IFCHK  = 4'd2;
    localparam logic [3:0] S_ISHRD  = 4'd3;
    localparam logic [3:0] S_ISHWR  = 4'd4;
    localparam logic [3:0] S_IWRITE = 4'd5;
    localparam logic [3:0] S_LRD    = 4'd6;
    localparam logic [3:0] S_LCHK   = 4'd7;
    localparam logic [3:0] S_LFETCH = 4'd8;
    localparam logic [3:0] S_LOUT   = 4'd9;
    localparam logic [3:0] S_RRD    = 4'd10;
    localparam logic [3:0] S_RCHK   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam int N = frt_pkg::TABLE_ENTRIES;
    localparam int IW = frt_pkg::IDX_W;
    localparam int CW = frt_pkg::CNT_W;

    frt_pkg::entry_t mem [N];
    frt_pkg::entry_t rd_data_reg;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]    best_reg, best_next;
    logic             found_reg, found_next;
    logic [63:0]      best_start_reg, best_start_next;
    logic             best_rec_reg, best_rec_next;
    frt_pkg::in_word_t  cmd_reg;
    frt_pkg::out_word_t res_reg, res_next;
    logic             out_valid_reg, out_valid_next;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    frt_pkg::entry_t  wr_data;

    logic             accept;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = res_reg;

    // Single-port table memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Captured command word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            wr_ptr_reg     <= '0;
            best_reg       <= '0;
            found_reg      <= 1'b0;
            best_start_reg <= '0;
            best_rec_reg   <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            wr_ptr_reg     <= wr_ptr_next;
            best_reg       <= best_next;
            found_reg      <= found_next;
            best_start_reg <= best_start_next;
            best_rec_reg   <= best_rec_next;
            res_reg        <= res_next;
        end
    end

    // Sequencer: one memory access per cycle, one shared compare path.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        idx_next        = idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_rec_next   = best_rec_reg;
        res_next        = res_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next  = '0;
                    idx_next  = '0;
                    found_next = 1'b0;
                    wr_ptr_next = '0;
                    unique case (in_ch.data.command)
                        frt_pkg::CMD_INSERT:
                        begin
                            if (in_ch.data.address >= in_ch.data.end_address)
                            begin
                                res_next.status = frt_pkg::ST_BADRANGE;
                                state_next = S_DONE;
                            end
                            else if (count_reg == CW'(N))
                            begin
                                res_next.status = frt_pkg::ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_IFIND;
                            end
                        end
                        frt_pkg::CMD_LOOKUP:
                        begin
                            idx_next = count_reg;
                            state_next = S_LRD;
                        end
                        frt_pkg::CMD_REMOVE:
                        begin
                            state_next = S_RRD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Insert: find first entry whose start is not below the new start.
            S_IFIND:
            begin
                if (idx_reg == count_reg)
                begin
                    wr_ptr_next = idx_reg;
                    idx_next = count_reg;
                    state_next = S_ISHRD;
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_IFCHK;
                end
            end
            S_IFCHK:
            begin
                if (rd_data_reg.start_a < cmd_reg.address)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_IFIND;
                end
                else
                begin
                    wr_ptr_next = idx_reg;
                    idx_next = count_reg;
                    state_next = S_ISHRD;
                end
            end
            // Insert: shift entries up from the end, down to the insert point.
            S_ISHRD:
            begin
                if (idx_reg == wr_ptr_reg)
                begin
                    state_next = S_IWRITE;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(idx_reg - 1'b1);
                    state_next = S_ISHWR;
                end
            end
            S_ISHWR:
            begin
                wr_en = 1'b1;
                wr_addr = idx_reg[IW-1:0];
                idx_next = idx_reg - 1'b1;
                state_next = S_ISHRD;
            end
            S_IWRITE:
            begin
                wr_en = 1'b1;
                wr_addr = wr_ptr_reg[IW-1:0];
                wr_data.start_a  = cmd_reg.address;
                wr_data.end_a    = cmd_reg.end_address;
                wr_data.owner    = (cmd_reg.owner_address != 64'd0) ?
                                   cmd_reg.owner_address : cmd_reg.address;
                wr_data.recovery = cmd_reg.recovery_address;
                wr_data.guest    = cmd_reg.guest_location;
                count_next = count_reg + 1'b1;
                res_next.status = frt_pkg::ST_OK;
                state_next = S_DONE;
            end
            // Lookup: scan downward, keep the best containing entry.
            S_LRD:
            begin
                if (idx_reg == '0)
                begin
                    if (found_reg)
                    begin
                        rd_en = 1'b1;
                        rd_addr = best_reg[IW-1:0];
                        state_next = S_LFETCH;
                    end
                    else
                    begin
                        res_next.status = frt_pkg::ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(idx_reg - 1'b1);
                    state_next = S_LCHK;
                end
            end
            S_LCHK:
            begin
                if (rd_data_reg.start_a <= cmd_reg.address &&
                    cmd_reg.address < rd_data_reg.end_a)
                begin
                    if (!found_reg || rd_data_reg.start_a > best_start_reg ||
                        (rd_data_reg.start_a == best_start_reg &&
                         rd_data_reg.recovery != 64'd0 && !best_rec_reg))
                    begin
                        found_next = 1'b1;
                        best_next = idx_reg - 1'b1;
                        best_start_next = rd_data_reg.start_a;
                        best_rec_next = (rd_data_reg.recovery != 64'd0);
                    end
                end
                idx_next = idx_reg - 1'b1;
                state_next = S_LRD;
            end
            S_LFETCH:
            begin
                state_next = S_LOUT;
            end
            S_LOUT:
            begin
                res_next.status       = frt_pkg::ST_OK;
                res_next.hit_start    = rd_data_reg.start_a;
                res_next.hit_end      = rd_data_reg.end_a;
                res_next.hit_owner    = rd_data_reg.owner;
                res_next.hit_recovery = rd_data_reg.recovery;
                res_next.hit_guest    = rd_data_reg.guest;
                state_next = S_DONE;
            end
            // Remove: compact survivors toward the front.
            S_RRD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next.removed_count = 7'(count_reg - wr_ptr_reg);
                    count_next = wr_ptr_reg;
                    res_next.status = frt_pkg::ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (rd_data_reg.owner != cmd_reg.address)
                begin
                    wr_en = 1'b1;
                    wr_addr = wr_ptr_reg[IW-1:0];
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = S_RRD;
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                end
                else if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_fault_range_table_top.sv =====
module tb_fault_range_table_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    frt_in_if  in_ch ();
    frt_out_if out_ch ();

    fault_range_table_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #4 clk = ~clk;

    // Shadow copy of the range table, kept sorted by start.
    frt_pkg::entry_t    shadow_tbl[$];
    frt_pkg::out_word_t pending_results[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    bit        stim_done = 1'b0;

    // Computes the result of one word and updates the shadow table.
    function automatic frt_pkg::out_word_t table_apply(frt_pkg::in_word_t w);
        frt_pkg::out_word_t r;
        frt_pkg::entry_t    e;
        int        pos;
        int        best;
        r = '0;
        case (w.command)
            frt_pkg::CMD_INSERT:
            begin
                if (w.address >= w.end_address)
                    r.status = frt_pkg::ST_BADRANGE;
                else if (shadow_tbl.size() >= frt_pkg::TABLE_ENTRIES)
                    r.status = frt_pkg::ST_FULL;
                else
                begin
                    e.start_a = w.address;
                    e.end_a = w.end_address;
                    e.owner = (w.owner_address != 64'd0) ? w.owner_address : w.address;
                    e.recovery = w.recovery_address;
                    e.guest = w.guest_location;
                    pos = 0;
                    while (pos < shadow_tbl.size() && shadow_tbl[pos].start_a < w.address)
                        pos++;
                    shadow_tbl.insert(pos, e);
                    r.status = frt_pkg::ST_OK;
                end
            end
            frt_pkg::CMD_LOOKUP:
            begin
                best = -1;
                for (int k = shadow_tbl.size() - 1; k >= 0; k--)
                begin
                    if (shadow_tbl[k].start_a <= w.address && w.address < shadow_tbl[k].end_a)
                    begin
                        if (best < 0 || shadow_tbl[k].start_a > shadow_tbl[best].start_a ||
                            (shadow_tbl[k].start_a == shadow_tbl[best].start_a &&
                             shadow_tbl[k].recovery != 64'd0 &&
                             shadow_tbl[best].recovery == 64'd0))
                            best = k;
                    end
                end
                if (best < 0)
                    r.status = frt_pkg::ST_NOTFOUND;
                else
                begin
                    r.status = frt_pkg::ST_OK;
                    r.hit_start = shadow_tbl[best].start_a;
                    r.hit_end = shadow_tbl[best].end_a;
                    r.hit_owner = shadow_tbl[best].owner;
                    r.hit_recovery = shadow_tbl[best].recovery;
                    r.hit_guest = shadow_tbl[best].guest;
                end
            end
            frt_pkg::CMD_REMOVE:
            begin
                pos = 0;
                for (int k = shadow_tbl.size() - 1; k >= 0; k--)
                begin
                    if (shadow_tbl[k].owner == w.address)
                    begin
                        shadow_tbl.delete(k);
                        pos++;
                    end
                end
                r.removed_count = 7'(pos);
                r.status = frt_pkg::ST_OK;
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Directed rows: a word plus an optional hand-written result.
    typedef struct {
        frt_pkg::in_word_t  w;
        bit                 has_fixed;
        frt_pkg::out_word_t fixed;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic frt_pkg::in_word_t mk_word(logic [1:0] c, logic [63:0] a,
                                                  logic [63:0] e, logic [63:0] o,
                                                  logic [63:0] rc, logic [63:0] g);
        frt_pkg::in_word_t w;
        w.command = c;
        w.address = a;
        w.end_address = e;
        w.owner_address = o;
        w.recovery_address = rc;
        w.guest_location = g;
        return w;
    endfunction

    function automatic void add_row(frt_pkg::in_word_t w, bit fx, logic [1:0] st);
        dir_row_t  d;
        d.w = w;
        d.has_fixed = fx;
        d.fixed = '0;
        d.fixed.status = st;
        dir_rows = {dir_rows, d};
    endfunction

    // Small address pool so that ranges overlap and owners repeat.
    function automatic logic [63:0] rand_addr();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = {$urandom, $urandom};
            1: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
            default: v = 64'($urandom_range(0, 60)) << ($urandom_range(0, 1) * 40);
        endcase
        return v;
    endfunction

    function automatic frt_pkg::in_word_t rand_word(int fill_bias);
        frt_pkg::in_word_t w;
        int       p;
        logic [63:0] a;
        p = $urandom_range(0, 99);
        a = rand_addr();
        w.address = a;
        w.end_address = ($urandom_range(0, 9) == 0) ? rand_addr()
                        : a + 64'($urandom_range(1, 20));
        if (w.end_address == 64'd0)
            w.end_address = 64'hFFFF_FFFF_FFFF_FFFF;
        w.owner_address = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 8));
        w.recovery_address = ($urandom_range(0, 1) == 0) ? 64'd0 : {$urandom, $urandom};
        w.guest_location = {$urandom, $urandom};
        if (p < fill_bias)
            w.command = frt_pkg::CMD_INSERT;
        else if (p < 90)
            w.command = frt_pkg::CMD_LOOKUP;
        else if (p < 98)
        begin
            w.command = frt_pkg::CMD_REMOVE;
            w.address = ($urandom_range(0, 4) == 0) ? rand_addr() : 64'($urandom_range(1, 8));
        end
        else
            w.command = frt_pkg::CMD_UNUSED;
        if (w.command == frt_pkg::CMD_LOOKUP && shadow_tbl.size() > 0 &&
            $urandom_range(0, 2) != 0)
        begin
            p = $urandom_range(0, shadow_tbl.size() - 1);
            w.address = shadow_tbl[p].start_a +
                        64'($urandom_range(0, 3)) % (shadow_tbl[p].end_a - shadow_tbl[p].start_a);
        end
        return w;
    endfunction

    // Sender: one word at a time, idling now and then. Valid stays up after the
    // accepting edge until the next word or an idle cycle replaces it.
    task automatic send_word(frt_pkg::in_word_t w, bit quiet);
        while (!quiet && $urandom_range(0, 99) < 22)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic issue(frt_pkg::in_word_t w, bit has_fixed, frt_pkg::out_word_t fixed,
                         bit quiet);
        frt_pkg::out_word_t r;
        r = table_apply(w);
        if (has_fixed && r != fixed)
        begin
            $display("%0t: directed row disagrees: expected %h predicted %h", $time, fixed, r);
            error_count++;
        end
        pending_results = {pending_results, r};
        send_word(w, quiet);
    endtask

    initial
    begin
        frt_pkg::in_word_t  w;
        frt_pkg::out_word_t fx;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, extremes, bad ranges, full table.
        add_row(mk_word(frt_pkg::CMD_LOOKUP, 64'd0, '0, '0, '0, '0), 1'b1,
                frt_pkg::ST_NOTFOUND);
        add_row(mk_word(frt_pkg::CMD_REMOVE, 64'd5, '0, '0, '0, '0), 1'b1, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_INSERT, 64'd10, 64'd10, '0, '0, '0), 1'b1,
                frt_pkg::ST_BADRANGE);
        add_row(mk_word(frt_pkg::CMD_INSERT, '1, 64'd0, '0, '0, '0), 1'b1,
                frt_pkg::ST_BADRANGE);
        add_row(mk_word(frt_pkg::CMD_INSERT, 64'd0, '1, '0, '0, '1), 1'b1, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_INSERT, 64'd100, 64'd200, 64'd7, '0, 64'h1), 1'b1,
                frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_INSERT, 64'd100, 64'd150, 64'd7, '1, 64'h2), 1'b1,
                frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_INSERT, 64'd100, 64'd300, 64'd8, '0, 64'h3), 1'b1,
                frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_LOOKUP, 64'd120, '0, '0, '0, '0), 1'b0, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_LOOKUP, 64'd250, '0, '0, '0, '0), 1'b0, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_LOOKUP, '1, '0, '0, '0, '0), 1'b1, frt_pkg::ST_NOTFOUND);
        add_row(mk_word(frt_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0, '0), 1'b0,
                frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_UNUSED, '1, '1, '1, '1, '1), 1'b1, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_REMOVE, 64'd7, '0, '0, '0, '0), 1'b0, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_REMOVE, 64'd0, '0, '0, '0, '0), 1'b0, frt_pkg::ST_OK);
        add_row(mk_word(frt_pkg::CMD_LOOKUP, 64'd120, '0, '0, '0, '0), 1'b0, frt_pkg::ST_OK);
        foreach (dir_rows[i])
            issue(dir_rows[i].w, dir_rows[i].has_fixed, dir_rows[i].fixed, 1'b0);

        // Fill the table to the top, then one more insert must report full.
        while (shadow_tbl.size() < frt_pkg::TABLE_ENTRIES)
        begin
            w = mk_word(frt_pkg::CMD_INSERT, 64'($urandom_range(0, 500)), 64'd600,
                        64'($urandom_range(0, 5)), '0, {$urandom, $urandom});
            issue(w, 1'b0, '0, 1'b0);
        end
        w = mk_word(frt_pkg::CMD_INSERT, 64'd1, 64'd2, '0, '0, '0);
        fx = '0;
        fx.status = frt_pkg::ST_FULL;
        issue(w, 1'b1, fx, 1'b0);
        issue(mk_word(frt_pkg::CMD_REMOVE, '1, '0, '0, '0, '0), 1'b0, '0, 1'b0);
        for (int o = 0; o <= 5; o++)
            issue(mk_word(frt_pkg::CMD_REMOVE, 64'(o), '0, '0, '0, '0), 1'b0, '0, 1'b0);

        // Pause until everything is back.
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // Random part; the insert share drifts so the table swings between empty and full.
        for (int n = 0; n < 1800; n++)
        begin
            w = rand_word(((n / 300) % 2 == 0) ? 55 : 25);
            issue(w, 1'b0, '0, (n >= 800 && n < 1000));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    initial
    begin
        int rx_cycles;
        rx_cycles = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles > 3000 && rx_cycles < 3400)
                out_ch.ready <= 1'b0;
            else if (rx_cycles > 60000 && rx_cycles < 70000)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= 22);
        end
    end

    // Result check against the oldest expectation.
    always @(posedge clk)
    begin
        frt_pkg::out_word_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_ch.data);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_ch.data.status !== exp_r.status ||
                    out_ch.data.hit_start !== exp_r.hit_start ||
                    out_ch.data.hit_end !== exp_r.hit_end ||
                    out_ch.data.hit_owner !== exp_r.hit_owner ||
                    out_ch.data.hit_recovery !== exp_r.hit_recovery ||
                    out_ch.data.hit_guest !== exp_r.hit_guest ||
                    out_ch.data.removed_count !== exp_r.removed_count)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_ch.data);
                    error_count++;
                end
            end
        end
    end

    // Cycle limit and end of run.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (stim_done && pending_results.size() == 0)
            begin
                repeat (200) @(posedge clk);
                if (error_count == 0 && pending_results.size() == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
